// ----- sv/ajq_pkg.sv -----
// Shared types and constants for the audio jitter queue.
package ajq_pkg;

    // Input item kinds carried on the slave-side tuser
    typedef enum logic [2:0] {
        KIND_PACKET     = 3'd0,
        KIND_TICK       = 3'd1,
        KIND_WRITE_DONE = 3'd2,
        KIND_START      = 3'd3,
        KIND_STOP       = 3'd4,
        KIND_MUTE       = 3'd5,
        KIND_RESUME     = 3'd6,
        KIND_DISCONNECT = 3'd7
    } kind_t;

    // Result actions
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_QUEUE_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_PREBUFFER_LEVEL = 2'd1;
    localparam logic [1:0] CFG_CREDIT_LIMIT    = 2'd2;

    // Field widths
    localparam int HANDLE_W = 16;
    localparam int LENGTH_W = 16;
    localparam int LEVEL_W  = 5;
    localparam int CREDIT_W = 6;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0]  QUEUE_LIMIT_RST     = 5'd14;
    localparam logic [LEVEL_W-1:0]  PREBUFFER_LEVEL_RST = 5'd5;
    localparam logic [CREDIT_W-1:0] CREDIT_LIMIT_RST    = 6'd14;

    // One queued packet descriptor
    typedef struct packed {
        logic [LENGTH_W-1:0] length;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

endpackage

// ----- sv/ajq_ram.sv -----
// Slot memory for packet descriptors: one write port, one registered read port.
module ajq_ram
    import ajq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  slot_t             wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output slot_t             rdata
);

    slot_t mem [DEPTH];

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one slot; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/audio_jitter_queue_credit_drain.sv -----
// Audio jitter queue: an accepted input item is held in the item registers, and a result
// state (S_SINGLE, S_POP or S_DROP) loads each result into the output register once it is
// free. Sending or releasing queued packets takes one slot memory read per result.
// The next item is accepted once the previous item's last result is in the output register.
// rst_n clears pointers, counts and flags at once and loads the register defaults;
// slot contents are not cleared and no clearing pass runs.
module audio_jitter_queue_credit_drain
    import ajq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pkt_handle[15:0], pkt_length[31:16], sink_ok[32]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_handle[15:0], out_length[31:16],
                                        // queue_level[36:32], in_flight[42:37], running[43]
    output logic [1:0]  m_axis_tuser,   // action[1:0]
    output logic        m_axis_tlast    // last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > LEVEL_W) ? CNT_W : LEVEL_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_POP,
        S_DROP
    } state_t;

    // Control state
    state_t              state_reg,   state_next;
    logic [PTR_W-1:0]    head_reg,    head_next;
    logic [PTR_W-1:0]    tail_reg,    tail_next;
    logic [CNT_W-1:0]    fill_reg,    fill_next;
    logic [CREDIT_W-1:0] credits_reg, credits_next;
    logic                run_reg,     run_next;
    logic                mute_reg,    mute_next;
    logic                drain_reg,   drain_next;
    logic [LEVEL_W-1:0]  qlimit_reg,  qlimit_next;
    logic [LEVEL_W-1:0]  prebuf_reg,  prebuf_next;
    logic [CREDIT_W-1:0] climit_reg,  climit_next;

    // Item held while its results go out
    logic [HANDLE_W-1:0] pkt_handle_reg, pkt_handle_next;
    logic [LENGTH_W-1:0] pkt_length_reg, pkt_length_next;
    action_t             res_action_reg, res_action_next;
    logic                send_reg,       send_next;

    // Output register
    logic                out_valid_reg,  out_valid_next;
    action_t             out_action_reg, out_action_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [LENGTH_W-1:0] out_length_reg, out_length_next;
    logic                out_last_reg,   out_last_next;
    logic [LEVEL_W-1:0]  out_level_reg,  out_level_next;
    logic [CREDIT_W-1:0] out_flight_reg, out_flight_next;
    logic                out_run_reg,    out_run_next;

    // Slot memory port
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    slot_t            ram_wdata;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    slot_t            ram_rdata;

    // Decode helpers
    kind_t               in_kind;
    logic [HANDLE_W-1:0] in_handle;
    logic [LENGTH_W-1:0] in_length;
    logic                in_sink_ok;
    logic                out_free;
    logic [PTR_W-1:0]    head_inc;
    logic [PTR_W-1:0]    tail_inc;
    logic [CMP_W-1:0]    fill_ext;
    logic [CMP_W-1:0]    lim_ext;
    logic [CNT_W-1:0]    fill_dec;
    logic [CREDIT_W-1:0] credits_add;
    logic                mute_eff;
    logic                cont;

    ajq_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_kind    = kind_t'(s_axis_tuser);
    assign in_handle  = s_axis_tdata[15:0];
    assign in_length  = s_axis_tdata[31:16];
    assign in_sink_ok = s_axis_tdata[32];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Wrap pointers at the queue depth
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // Clamp the queue limit to 1..QUEUE_DEPTH
    assign fill_ext = CMP_W'(fill_reg);
    always_comb
    begin
        lim_ext = CMP_W'(qlimit_reg);
        if (lim_ext == '0)
        begin
            lim_ext = CMP_W'(1);
        end
        else if (lim_ext > CMP_W'(QUEUE_DEPTH))
        begin
            lim_ext = CMP_W'(QUEUE_DEPTH);
        end
    end

    assign fill_dec    = fill_reg - 1'b1;
    assign credits_add = send_reg ? credits_reg + 1'b1 : credits_reg;
    assign cont        = (fill_dec != '0) && (!send_reg || (credits_add < climit_reg));
    assign mute_eff    = (in_kind == KIND_RESUME) ? 1'b0 : mute_reg;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        credits_next    = credits_reg;
        run_next        = run_reg;
        mute_next       = mute_reg;
        drain_next      = drain_reg;
        qlimit_next     = qlimit_reg;
        prebuf_next     = prebuf_reg;
        climit_next     = climit_reg;
        pkt_handle_next = pkt_handle_reg;
        pkt_length_next = pkt_length_reg;
        res_action_next = res_action_reg;
        send_next       = send_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_action_next = out_action_reg;
        out_handle_next = out_handle_reg;
        out_length_next = out_length_reg;
        out_last_next   = out_last_reg;
        out_level_next  = out_level_reg;
        out_flight_next = out_flight_reg;
        out_run_next    = out_run_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = '{length: pkt_length_reg, handle: pkt_handle_reg};
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        // Load configuration registers
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUEUE_LIMIT:     qlimit_next = cfg_data[LEVEL_W-1:0];
                CFG_PREBUFFER_LEVEL: prebuf_next = cfg_data[LEVEL_W-1:0];
                CFG_CREDIT_LIMIT:    climit_next = cfg_data;
                default:             ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pkt_handle_next = in_handle;
                    pkt_length_next = in_length;
                    res_action_next = ACT_NONE;
                    state_next      = S_SINGLE;
                    ram_wdata       = '{length: in_length, handle: in_handle};
                    unique case (in_kind)
                        KIND_PACKET:
                        begin
                            if (!run_reg)
                            begin
                                res_action_next = ACT_RELEASE;
                            end
                            else if (fill_ext >= lim_ext)
                            begin
                                // fetch the oldest slot, then replace it
                                ram_re     = 1'b1;
                                state_next = S_DROP;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                tail_next = tail_inc;
                                fill_next = fill_reg + 1'b1;
                                if ((fill_ext + CMP_W'(1)) >= CMP_W'(prebuf_reg))
                                begin
                                    drain_next = 1'b1;
                                end
                            end
                        end
                        KIND_TICK:
                        begin
                            if (drain_reg && (fill_reg != '0) &&
                                (credits_reg < climit_reg) && in_sink_ok)
                            begin
                                ram_re     = 1'b1;
                                send_next  = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        KIND_WRITE_DONE:
                        begin
                            if (credits_reg != '0)
                            begin
                                credits_next = credits_reg - 1'b1;
                            end
                        end
                        KIND_START, KIND_RESUME:
                        begin
                            mute_next = mute_eff;
                            if (!mute_eff && !run_reg)
                            begin
                                run_next = 1'b1;
                                if (fill_reg != '0)
                                begin
                                    ram_re     = 1'b1;
                                    send_next  = 1'b0;
                                    state_next = S_POP;
                                end
                                else
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                            end
                        end
                        KIND_STOP, KIND_MUTE, KIND_DISCONNECT:
                        begin
                            if (in_kind == KIND_MUTE)
                            begin
                                mute_next = 1'b1;
                            end
                            else if (in_kind == KIND_DISCONNECT)
                            begin
                                mute_next = 1'b0;
                            end
                            if (run_reg)
                            begin
                                run_next   = 1'b0;
                                drain_next = 1'b0;
                                if (fill_reg != '0)
                                begin
                                    ram_re     = 1'b1;
                                    send_next  = 1'b0;
                                    state_next = S_POP;
                                end
                                else
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SINGLE:
            begin
                // Emit the lone result of this item
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = res_action_reg;
                    out_handle_next = (res_action_reg == ACT_NONE) ? '0 : pkt_handle_reg;
                    out_length_next = (res_action_reg == ACT_NONE) ? '0 : pkt_length_reg;
                    out_last_next   = 1'b1;
                    out_level_next  = LEVEL_W'(fill_reg);
                    out_flight_next = credits_reg;
                    out_run_next    = run_reg;
                    state_next      = S_IDLE;
                end
            end

            S_POP:
            begin
                // Send or release the head slot, fetch the next one if the run goes on
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = send_reg ? ACT_SEND : ACT_RELEASE;
                    out_handle_next = ram_rdata.handle;
                    out_length_next = ram_rdata.length;
                    out_last_next   = !cont;
                    out_level_next  = LEVEL_W'(fill_dec);
                    out_flight_next = credits_add;
                    out_run_next    = run_reg;
                    head_next       = head_inc;
                    fill_next       = fill_dec;
                    credits_next    = credits_add;
                    if (cont)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = head_inc;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (!send_reg)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
            end

            S_DROP:
            begin
                // Release the oldest slot and store the new packet at the tail
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = ACT_RELEASE;
                    out_handle_next = ram_rdata.handle;
                    out_length_next = ram_rdata.length;
                    out_last_next   = 1'b1;
                    out_level_next  = LEVEL_W'(fill_reg);
                    out_flight_next = credits_reg;
                    out_run_next    = run_reg;
                    head_next       = head_inc;
                    tail_next       = tail_inc;
                    ram_we          = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            credits_reg    <= '0;
            run_reg        <= 1'b0;
            mute_reg       <= 1'b0;
            drain_reg      <= 1'b0;
            qlimit_reg     <= QUEUE_LIMIT_RST;
            prebuf_reg     <= PREBUFFER_LEVEL_RST;
            climit_reg     <= CREDIT_LIMIT_RST;
            send_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            credits_reg    <= credits_next;
            run_reg        <= run_next;
            mute_reg       <= mute_next;
            drain_reg      <= drain_next;
            qlimit_reg     <= qlimit_next;
            prebuf_reg     <= prebuf_next;
            climit_reg     <= climit_next;
            send_reg       <= send_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pkt_handle_reg <= pkt_handle_next;
        pkt_length_reg <= pkt_length_next;
        res_action_reg <= res_action_next;
        out_action_reg <= out_action_next;
        out_handle_reg <= out_handle_next;
        out_length_reg <= out_length_next;
        out_last_reg   <= out_last_next;
        out_level_reg  <= out_level_next;
        out_flight_reg <= out_flight_next;
        out_run_reg    <= out_run_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {4'b0000, out_run_reg, out_flight_reg, out_level_reg,
                            out_length_reg, out_handle_reg};

    // Queue never holds more than its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill exceeds depth");

    // A slot read is only in progress while the queue holds something
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP || state_reg == S_DROP) |-> fill_reg != '0)
        else $error("slot read with empty queue");

    // Drain is armed only while running
    a_drain_run: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> run_reg)
        else $error("drain armed while stopped");

    // Between items, a stopped stream holds no packets
    a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !run_reg) |-> fill_reg == '0)
        else $error("packets queued while stopped");

endmodule
